// File: sv/number_to_ascii_formatter_defines.svh
// assertion macros for the number to ascii formatter checker
// no dependencies; included by the checker file only
`ifndef NUMBER_TO_ASCII_FORMATTER_DEFINES_SVH
`define NUMBER_TO_ASCII_FORMATTER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define NTAF_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ntaf same-cycle check failed");

// next-cycle implication, disabled during reset
`define NTAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ntaf next-cycle check failed");

`endif

// File: sv/ntaf_pkg.sv
// shared mode codes, ascii constants and digit limits for the number to ascii formatter
// no dependencies; used by the top level and the checker
package ntaf_pkg;

  localparam logic [1:0] MODE_UDEC = 2'd0;
  localparam logic [1:0] MODE_SDEC = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;
  localparam logic [1:0] MODE_BIN  = 2'd3;

  localparam logic [6:0] CHR_ZERO  = 7'h30;
  localparam logic [6:0] CHR_A     = 7'h41;
  localparam logic [6:0] CHR_PLUS  = 7'h2B;
  localparam logic [6:0] CHR_MINUS = 7'h2D;

  localparam logic [4:0] MAX_DEC = 5'd10;
  localparam logic [4:0] MAX_HEX = 5'd8;
  localparam logic [4:0] MAX_BIN = 5'd16;

  localparam int BCD_DIGITS = 10;

endpackage

// File: sv/number_to_ascii_formatter.sv
// number to ascii formatter: top level, sequencer, shift-and-add-3 unit, output register
// depends on ntaf_pkg
//
//   channel  | direction | handshake                   | payload
//   ---------+-----------+-----------------------------+------------------------------------
//   number   | in        | number_valid / number_stall | mode, number_value, digit_count,
//            |           |                             | row, start_column
//   char     | out       | char_valid / char_stall     | row_out, column_out, ascii_char, last
//
// decimal modes: a load, then the bcd unit shifts in every bit of the magnitude, then one
//   character per cycle while the output register is free (sign in signed mode plus up to 10 digits)
// hex and binary: a load, then one digit per cycle while the output register is free (up to 8 or 16)
// number_stall stays high from the accept until the last character, if any, is in the output register
// a stalled char request holds its payload; the next number request is taken meanwhile
// rst is synchronous and clears the sequencer and the output valid
module number_to_ascii_formatter #(
  parameter int NUMBER_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       number_valid,
  output logic       number_stall,
  input  logic [1:0] mode,
  input  logic [31:0] number_value,
  input  logic [4:0] digit_count,
  input  logic [2:0] row,
  input  logic [4:0] start_column,
  output logic       char_valid,
  input  logic       char_stall,
  output logic [2:0] row_out,
  output logic [4:0] column_out,
  output logic [6:0] ascii_char,
  output logic       last
);

  localparam int CW = $clog2(NUMBER_WIDTH);

  // sequencer codes
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SIGN = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]              state;
  logic [1:0]              state_next;
  logic [1:0]              mode_q;
  logic                    neg_q;
  logic                    zero_q;
  logic [3:0]              idx;
  logic [4:0]              col;
  logic [2:0]              row_q;
  logic [CW-1:0]           bit_cnt;
  logic [NUMBER_WIDTH-1:0] mag;
  logic [3:0]              bcd [ntaf_pkg::BCD_DIGITS];
  logic [3:0]              bcd_shift [ntaf_pkg::BCD_DIGITS];

  // input view of the number, at the working width and at 32 bits
  logic [NUMBER_WIDTH-1:0] v_nw;
  logic [31:0]             v_32;

  generate
    if (NUMBER_WIDTH > 32) begin : g_wide
      assign v_nw = {{(NUMBER_WIDTH - 32){1'b0}}, number_value};
      assign v_32 = number_value;
    end else if (NUMBER_WIDTH == 32) begin : g_full
      assign v_nw = number_value;
      assign v_32 = number_value;
    end else begin : g_narrow
      assign v_nw = number_value[NUMBER_WIDTH-1:0];
      assign v_32 = {{(32 - NUMBER_WIDTH){1'b0}}, number_value[NUMBER_WIDTH-1:0]};
    end
  endgenerate

  logic       accept;
  logic       is_dec;
  logic       neg_in;
  logic [4:0] max_cnt;
  logic [4:0] cnt_c;

  assign accept = number_valid && (state == S_IDLE);
  assign number_stall = (state != S_IDLE);

  // digit count clamp per mode
  always_comb begin
    unique case (mode) inside
      ntaf_pkg::MODE_UDEC, ntaf_pkg::MODE_SDEC: max_cnt = ntaf_pkg::MAX_DEC;
      ntaf_pkg::MODE_HEX:                       max_cnt = ntaf_pkg::MAX_HEX;
      default:                                  max_cnt = ntaf_pkg::MAX_BIN;
    endcase
  end

  assign cnt_c  = (digit_count > max_cnt) ? max_cnt : digit_count;
  assign is_dec = (mode == ntaf_pkg::MODE_UDEC) || (mode == ntaf_pkg::MODE_SDEC);
  assign neg_in = (mode == ntaf_pkg::MODE_SDEC) && v_nw[NUMBER_WIDTH-1];

  // shared bcd unit: add 3 to every digit of five or more, then shift in the next bit
  always_comb begin
    logic [3:0] adj [ntaf_pkg::BCD_DIGITS];
    for (int k = 0; k < ntaf_pkg::BCD_DIGITS; k++) begin
      adj[k] = (bcd[k] >= 4'd5) ? (bcd[k] + 4'd3) : bcd[k];
    end
    for (int k = 0; k < ntaf_pkg::BCD_DIGITS; k++) begin
      if (k == 0) begin
        bcd_shift[k] = {adj[k][2:0], mag[NUMBER_WIDTH-1]};
      end else begin
        bcd_shift[k] = {adj[k][2:0], adj[k-1][3]};
      end
    end
  end

  // digit at the emit index, as ascii
  logic [3:0] nib;
  logic       bin_bit;
  logic [3:0] digit;
  logic [6:0] digit_chr;

  assign nib     = (idx < 4'(ntaf_pkg::BCD_DIGITS)) ? bcd[idx] : 4'd0;
  assign bin_bit = bcd[{2'b00, idx[3:2]}][idx[1:0]];
  assign digit   = (mode_q == ntaf_pkg::MODE_BIN) ? {3'b000, bin_bit} : nib;
  assign digit_chr = (digit < 4'd10) ? (ntaf_pkg::CHR_ZERO + {3'b000, digit})
                                     : (ntaf_pkg::CHR_A + {3'b000, digit} - 7'd10);

  // output register is free when empty or being taken this cycle
  logic out_free;
  logic emit_sign;
  logic emit_digit;

  assign out_free   = !char_valid || !char_stall;
  assign emit_sign  = (state == S_SIGN) && out_free;
  assign emit_digit = (state == S_EMIT) && out_free;

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (is_dec) begin
            state_next = S_CONV;
          end else if (cnt_c == 5'd0) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_CONV: begin
        if (bit_cnt == '0) begin
          if (mode_q == ntaf_pkg::MODE_SDEC) begin
            state_next = S_SIGN;
          end else if (zero_q) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_EMIT;
          end
        end
      end
      S_SIGN: begin
        if (out_free) begin
          state_next = zero_q ? S_IDLE : S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free && (idx == 4'd0)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q  <= mode;
      neg_q   <= neg_in;
      zero_q  <= (cnt_c == 5'd0);
      idx     <= 4'(cnt_c - 5'd1);
      col     <= start_column;
      row_q   <= row;
      bit_cnt <= CW'(NUMBER_WIDTH - 1);
      // magnitude for the decimal modes, wraps for the most negative value
      mag     <= neg_in ? (NUMBER_WIDTH'(0) - v_nw) : v_nw;
      for (int k = 0; k < ntaf_pkg::BCD_DIGITS; k++) begin
        if (!is_dec && (k < 8)) begin
          bcd[k] <= v_32[4*k +: 4];
        end else begin
          bcd[k] <= 4'd0;
        end
      end
    end else if (state == S_CONV) begin
      bit_cnt <= bit_cnt - CW'(1);
      mag     <= {mag[NUMBER_WIDTH-2:0], 1'b0};
      for (int k = 0; k < ntaf_pkg::BCD_DIGITS; k++) begin
        bcd[k] <= bcd_shift[k];
      end
    end else if (emit_sign) begin
      col <= col + 5'd1;
    end else if (emit_digit) begin
      col <= col + 5'd1;
      idx <= idx - 4'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (emit_sign || emit_digit) begin
      char_valid <= 1'b1;
    end else if (!char_stall) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_sign) begin
      row_out    <= row_q;
      column_out <= col;
      ascii_char <= neg_q ? ntaf_pkg::CHR_MINUS : ntaf_pkg::CHR_PLUS;
      last       <= zero_q;
    end else if (emit_digit) begin
      row_out    <= row_q;
      column_out <= col;
      ascii_char <= digit_chr;
      last       <= (idx == 4'd0);
    end
  end

endmodule

// File: sv/ntaf_checker.sv
// port-level checker for the number to ascii formatter, bound to the top level
// depends on ntaf_pkg and number_to_ascii_formatter_defines.svh
`include "number_to_ascii_formatter_defines.svh"

module ntaf_checker (
  input logic       clk,
  input logic       rst,
  input logic       number_valid,
  input logic       number_stall,
  input logic [4:0] digit_count,
  input logic       char_valid,
  input logic       char_stall,
  input logic [6:0] ascii_char,
  input logic       last
);

  // busy right after a request with a nonzero count is taken
  `NTAF_ASSERT_NEXT(a_busy_after_accept, clk, rst,
    number_valid && !number_stall && (digit_count != 5'd0), number_stall)

  // a run is not over while a character that is not its last is on the port
  `NTAF_ASSERT_SAME(a_busy_mid_run, clk, rst, char_valid && !last, number_stall)

  // stalled character holds
  `NTAF_ASSERT_NEXT(a_char_hold, clk, rst, char_valid && char_stall,
    char_valid && $stable(ascii_char) && $stable(last))

  // only digits, A to F and signs come out
  `NTAF_ASSERT_SAME(a_char_legal, clk, rst, char_valid,
    ((ascii_char >= ntaf_pkg::CHR_ZERO) && (ascii_char <= ntaf_pkg::CHR_ZERO + 7'd9)) ||
    ((ascii_char >= ntaf_pkg::CHR_A) && (ascii_char <= ntaf_pkg::CHR_A + 7'd5)) ||
    (ascii_char == ntaf_pkg::CHR_PLUS) || (ascii_char == ntaf_pkg::CHR_MINUS))

endmodule

bind number_to_ascii_formatter ntaf_checker u_ntaf_checker (
  .clk          (clk),
  .rst          (rst),
  .number_valid (number_valid),
  .number_stall (number_stall),
  .digit_count  (digit_count),
  .char_valid   (char_valid),
  .char_stall   (char_stall),
  .ascii_char   (ascii_char),
  .last         (last)
);

// File: verif/number_to_ascii_formatter_test.sv
// self-checking testbench for number_to_ascii_formatter: directed and random number requests,
// every character compared against a built-in predictor of the formatting rules
// depends on ntaf_pkg and the number_to_ascii_formatter rtl
module number_to_ascii_formatter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_PERIOD     = 4;
  localparam int RESET_CYCLES    = 7;
  localparam int RANDOM_REQUESTS = 200;
  // a decimal request converts bit by bit, then emits its characters; leave plenty of room
  localparam int DRAIN_CYCLES    = 100;
  // longest legal quiet spell: sender gap + bcd conversion + receiver stall, well under this
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int MAX_PRINTED     = 50;

  // one number request as the sender presents it
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] value;
    logic [4:0]  count;
    logic [2:0]  row;
    logic [4:0]  column;
  } number_req_t;

  // one character as the block should deliver it
  typedef struct packed {
    logic [2:0] row;
    logic [4:0] column;
    logic [6:0] code;
    logic       last;
  } char_t;

  // every block input starts at a known value
  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        number_valid = 1'b0;
  logic        number_stall;
  logic [1:0]  mode         = ntaf_pkg::MODE_UDEC;
  logic [31:0] number_value = '0;
  logic [4:0]  digit_count  = '0;
  logic [2:0]  row          = '0;
  logic [4:0]  start_column = '0;
  logic        char_valid;
  logic        char_stall   = 1'b0;
  logic [2:0]  row_out;
  logic [4:0]  column_out;
  logic [6:0]  ascii_char;
  logic        last;

  number_req_t numbers_to_send[$];  // filled by the stimulus block, drained by the driver
  char_t       chars_due[$];        // predicted characters, oldest first

  int error_count    = 0;
  int numbers_taken  = 0;
  int chars_checked  = 0;
  int mode_taken[4]  = '{default: 0};

  number_to_ascii_formatter dut (.*);

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------------------------
  // predictor: turns one accepted request into the run of characters it must produce
  // ---------------------------------------------------------------------------------------------
  function automatic void predict_chars(input number_req_t req);
    logic [31:0] magnitude;
    logic [31:0] base;
    logic [3:0]  digit[16];
    int          limit;
    int          digits;
    int          pos;
    char_t       c;
    magnitude = req.value;
    case (req.mode)
      ntaf_pkg::MODE_HEX: begin
        limit = ntaf_pkg::MAX_HEX;
        base  = 32'd16;
      end
      ntaf_pkg::MODE_BIN: begin
        limit = ntaf_pkg::MAX_BIN;
        base  = 32'd2;
      end
      default: begin
        limit = ntaf_pkg::MAX_DEC;
        base  = 32'd10;
      end
    endcase
    // counts beyond what the mode can show are clamped
    digits = (int'(req.count) > limit) ? limit : int'(req.count);
    pos = 0;
    // signed mode leads with the sign; with no digits the sign alone closes the run
    if (req.mode == ntaf_pkg::MODE_SDEC) begin
      c.row    = req.row;
      c.column = req.column;
      c.code   = magnitude[31] ? ntaf_pkg::CHR_MINUS : ntaf_pkg::CHR_PLUS;
      c.last   = (digits == 0);
      chars_due.push_back(c);
      // the most negative value negates to itself, which is the right unsigned magnitude
      if (magnitude[31]) magnitude = 32'd0 - magnitude;
      pos = 1;
    end
    // low digits first; anything above the count is dropped, leading zeros stay
    for (int i = 0; i < digits; i++) begin
      digit[i]  = 4'(magnitude % base);
      magnitude = magnitude / base;
    end
    for (int i = digits - 1; i >= 0; i--) begin
      c.row    = req.row;
      c.column = req.column + 5'(pos);  // wraps modulo 32
      c.code   = (digit[i] < 4'd10) ? ntaf_pkg::CHR_ZERO + 7'(digit[i])
                                    : ntaf_pkg::CHR_A + 7'(digit[i]) - 7'd10;
      c.last   = (i == 0);
      chars_due.push_back(c);
      pos++;
    end
  endfunction

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("ERROR at %0t ns: %s", $time, what);
  endtask

  // pause length: mostly none or short, now and then long
  function automatic int random_pause(input int zero_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < zero_pct) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void queue_number(input logic [1:0] m, input logic [31:0] value,
                                       input logic [4:0] count, input logic [2:0] r,
                                       input logic [4:0] column);
    number_req_t req;
    req = '{m, value, count, r, column};
    numbers_to_send.push_back(req);
  endfunction

  // random request: mixed value classes, counts mostly in range with some zero and clamped
  function automatic number_req_t random_number();
    number_req_t req;
    int          limit;
    int          pick;
    req.mode = 2'($urandom_range(0, 3));
    limit = (req.mode == ntaf_pkg::MODE_HEX) ? ntaf_pkg::MAX_HEX :
            (req.mode == ntaf_pkg::MODE_BIN) ? ntaf_pkg::MAX_BIN : ntaf_pkg::MAX_DEC;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        case ($urandom_range(0, 3))
          0:       req.value = 32'h0000_0000;
          1:       req.value = 32'hFFFF_FFFF;
          2:       req.value = 32'h8000_0000;
          default: req.value = 32'h7FFF_FFFF;
        endcase
      end
      1, 2:    req.value = $urandom_range(0, 999);
      3:       req.value = 32'd0 - $urandom_range(1, 999);
      default: req.value = $urandom;
    endcase
    pick = $urandom_range(0, 19);
    if (pick == 0) req.count = 5'd0;
    else if (pick <= 2) req.count = 5'($urandom_range(limit + 1, 31));
    else req.count = 5'($urandom_range(1, limit));
    req.row    = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(1, 4));
    req.column = 5'($urandom_range(0, 31));
    return req;
  endfunction

  // ---------------------------------------------------------------------------------------------
  // driver: presents queued number requests, holds them while stalled, inserts random gaps
  // ---------------------------------------------------------------------------------------------
  number_req_t next_req;
  int          gap_left   = 0;
  int          calm_items = 0;

  always @(posedge clk) begin
    if (rst) begin
      number_valid <= 1'b0;
    end else begin
      // the request on the port right now is taken at this edge
      if (number_valid && !number_stall) begin
        predict_chars('{mode, number_value, digit_count, row, start_column});
        numbers_taken++;
        mode_taken[mode]++;
      end
      // a new request may only go out once the current one is gone
      if (!number_valid || !number_stall) begin
        if (gap_left != 0) begin
          gap_left     <= gap_left - 1;
          number_valid <= 1'b0;
        end else if (numbers_to_send.size() != 0) begin
          next_req      = numbers_to_send.pop_front();
          mode         <= next_req.mode;
          number_value <= next_req.value;
          digit_count  <= next_req.count;
          row          <= next_req.row;
          start_column <= next_req.column;
          number_valid <= 1'b1;
          // back-to-back stretches alternate with randomly gapped ones
          if (calm_items != 0) begin
            calm_items <= calm_items - 1;
            gap_left   <= 0;
          end else if ($urandom_range(0, 19) == 0) begin
            calm_items <= $urandom_range(8, 25);
            gap_left   <= 0;
          end else begin
            gap_left <= random_pause(50);
          end
        end else begin
          number_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // monitor: random stall on the char channel, each accepted character checked field by field
  // ---------------------------------------------------------------------------------------------
  char_t got;
  char_t want;
  int    stall_left  = 0;
  int    calm_cycles = 0;
  int    pause;

  always @(posedge clk) begin
    if (rst) begin
      char_stall <= 1'b0;
    end else begin
      if (char_valid && !char_stall) begin
        got = '{row_out, column_out, ascii_char, last};
        chars_checked++;
        if (chars_due.size() == 0) begin
          report_mismatch($sformatf("unexpected character 0x%02h at row %0d column %0d",
                                    got.code, got.row, got.column));
        end else begin
          want = chars_due.pop_front();
          if (got.row != want.row)
            report_mismatch($sformatf("character %0d: row %0d, expected %0d",
                                      chars_checked, got.row, want.row));
          if (got.column != want.column)
            report_mismatch($sformatf("character %0d: column %0d, expected %0d",
                                      chars_checked, got.column, want.column));
          if (got.code != want.code)
            report_mismatch($sformatf("character %0d: code 0x%02h, expected 0x%02h",
                                      chars_checked, got.code, want.code));
          if (got.last != want.last)
            report_mismatch($sformatf("character %0d: last %0b, expected %0b",
                                      chars_checked, got.last, want.last));
        end
      end
      // stall pattern: ongoing stall, a stall-free stretch, or a fresh random pause
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        char_stall <= 1'b1;
      end else if (calm_cycles != 0) begin
        calm_cycles <= calm_cycles - 1;
        char_stall  <= 1'b0;
      end else if ($urandom_range(0, 99) < 3) begin
        calm_cycles <= $urandom_range(20, 80);
        char_stall  <= 1'b0;
      end else begin
        pause = random_pause(65);
        char_stall <= (pause != 0);
        stall_left <= (pause != 0) ? pause - 1 : 0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // watchdog: too long without any handshake means the block hung
  // ---------------------------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((number_valid && !number_stall) || (char_valid && !char_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d characters still due",
                 idle_cycles, chars_due.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------------------------
  initial begin
    // unsigned decimal: full scale, zero, high digits dropped, clamped count, zero count
    queue_number(ntaf_pkg::MODE_UDEC, 32'hFFFF_FFFF, 5'd10, 3'd1, 5'd1);
    queue_number(ntaf_pkg::MODE_UDEC, 32'd0,         5'd10, 3'd2, 5'd1);
    queue_number(ntaf_pkg::MODE_UDEC, 32'd1234567890, 5'd4, 3'd3, 5'd5);
    queue_number(ntaf_pkg::MODE_UDEC, 32'd99,        5'd16, 3'd4, 5'd1);
    queue_number(ntaf_pkg::MODE_UDEC, 32'd12345,     5'd0,  3'd1, 5'd1);
    // signed decimal: most negative, most positive, minus one, sign only, clamped count
    queue_number(ntaf_pkg::MODE_SDEC, 32'h8000_0000, 5'd10, 3'd1, 5'd1);
    queue_number(ntaf_pkg::MODE_SDEC, 32'h7FFF_FFFF, 5'd10, 3'd2, 5'd2);
    queue_number(ntaf_pkg::MODE_SDEC, 32'hFFFF_FFFF, 5'd3,  3'd3, 5'd3);
    queue_number(ntaf_pkg::MODE_SDEC, 32'd0,         5'd0,  3'd4, 5'd4);
    queue_number(ntaf_pkg::MODE_SDEC, 32'hFFFF_FF85, 5'd31, 3'd1, 5'd6);
    // hexadecimal: letters, clamped count, truncated, zero count
    queue_number(ntaf_pkg::MODE_HEX,  32'hDEAD_BEEF, 5'd8,  3'd1, 5'd1);
    queue_number(ntaf_pkg::MODE_HEX,  32'hFEDC_BA98, 5'd31, 3'd2, 5'd9);
    queue_number(ntaf_pkg::MODE_HEX,  32'hABCD_EF01, 5'd3,  3'd3, 5'd1);
    queue_number(ntaf_pkg::MODE_HEX,  32'h1234_5678, 5'd0,  3'd4, 5'd1);
    // binary: full count, clamped count, single digit, zero count
    queue_number(ntaf_pkg::MODE_BIN,  32'h0000_A5A5, 5'd16, 3'd1, 5'd1);
    queue_number(ntaf_pkg::MODE_BIN,  32'hFFFF_FFFF, 5'd20, 3'd2, 5'd1);
    queue_number(ntaf_pkg::MODE_BIN,  32'd0,         5'd1,  3'd3, 5'd16);
    queue_number(ntaf_pkg::MODE_BIN,  32'd1,         5'd0,  3'd4, 5'd1);
    // column wrap past 31 and rows outside the display range
    queue_number(ntaf_pkg::MODE_UDEC, 32'd4000000000, 5'd10, 3'd0, 5'd31);
    queue_number(ntaf_pkg::MODE_SDEC, 32'd1,         5'd10, 3'd7, 5'd28);
    queue_number(ntaf_pkg::MODE_HEX,  32'h00C0_FFEE, 5'd8,  3'd5, 5'd0);
    queue_number(ntaf_pkg::MODE_BIN,  32'h0000_5555, 5'd16, 3'd6, 5'd31);
    for (int n = 0; n < RANDOM_REQUESTS; n++) numbers_to_send.push_back(random_number());

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // sample away from the active edge so the driver's queue updates have settled
    do @(negedge clk);
    while (numbers_to_send.size() != 0 || number_valid || chars_due.size() != 0);
    // a zero-count request may still be in flight; anything it emits is flagged as unexpected
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d number requests: %0d unsigned, %0d signed, %0d hex, %0d binary",
             numbers_taken, mode_taken[ntaf_pkg::MODE_UDEC], mode_taken[ntaf_pkg::MODE_SDEC],
             mode_taken[ntaf_pkg::MODE_HEX], mode_taken[ntaf_pkg::MODE_BIN]);
    $display("checked %0d characters, %0d mismatches", chars_checked, error_count);
    if (error_count == 0 && chars_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
